### rtl/core/hsc_pkg.sv
// Package for the Hamming single-error-correcting codec.
// Holds the field widths, the operation codes and the item types used by every file.
`timescale 1ns / 1ps

package hsc_pkg;

	localparam int MAX_DATA_BITS = 57;
	localparam int MAX_CODE_BITS = 63;
	localparam int DATA_BITS_W   = 6;
	localparam int SYND_W        = 6;

	localparam logic [DATA_BITS_W-1:0] DATA_BITS_RESET = 6'd4;

	typedef enum logic [0:0] {
		OP_ENCODE = 1'b0,
		OP_DECODE = 1'b1
	} op_t;

	typedef struct packed {
		op_t                      op;
		logic [MAX_DATA_BITS-1:0] data_word;
		logic [MAX_CODE_BITS-1:0] code_word;
	} cmd_t;

	typedef struct packed {
		logic [MAX_CODE_BITS-1:0] code_out;
		logic [SYND_W-1:0]        syndrome;
		logic                     corrected;
		logic                     syndrome_out_of_range;
	} res_t;

endpackage

### rtl/core/hsc_if.sv
// Valid/ready channel interfaces for the codec's command and result items.
// Depends on hsc_pkg for the item types.
`timescale 1ns / 1ps

interface hsc_cmd_if;
	logic          valid;
	logic          ready;
	hsc_pkg::cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface hsc_res_if;
	logic          valid;
	logic          ready;
	hsc_pkg::res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/hamming_sec_codec_top.sv
// Top level of the Hamming single-error-correcting codec.
// Depends on hsc_pkg, the channel interfaces in hsc_if and the datapath in hsc_core.
//
// Usage:
// Command items arrive on cmd (valid/ready). An item with op OP_ENCODE takes
// data_word and returns its codeword; an item with op OP_DECODE takes code_word,
// returns the syndrome and the corrected word, and flags a syndrome beyond the
// codeword length. Result items leave on res (valid/ready), one per command item,
// in order.
// The data_bits register sets the number of data bits per codeword; write it with
// cfg_we and cfg_wdata while no item is in flight.
// A command item is captured in the input register when it is accepted, passes
// through the parity XOR trees and the correction, and is then captured in the
// result register, from which it is valid on res and can leave.
// Throughput is one item per cycle unless res stalls; the two registers form a
// pipeline in which every stage advances when the stage after it is empty or is
// being drained. When res is stalled, the result holds and cmd keeps accepting
// until the input register is also full.
// Reset clears both pipeline stages and sets data_bits to 4.
`timescale 1ns / 1ps

module hamming_sec_codec_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [hsc_pkg::DATA_BITS_W-1:0] cfg_wdata,
	hsc_cmd_if.sink                         cmd,
	hsc_res_if.source                       res
);

	logic [hsc_pkg::DATA_BITS_W-1:0] data_bits_q;
	logic                            valid_s1;
	hsc_pkg::cmd_t                   item_s1;
	logic                            valid_s2;
	hsc_pkg::res_t                   item_s2;
	hsc_pkg::res_t                   core_res;
	logic                            adv_s2;

	assign adv_s2    = !valid_s2 || res.ready;
	assign cmd.ready = !valid_s1 || adv_s2;
	assign res.valid = valid_s2;
	assign res.data  = item_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_bits_q <= hsc_pkg::DATA_BITS_RESET;
		end else if (cfg_we) begin
			data_bits_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cmd.ready) begin
				valid_s1 <= cmd.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1 <= cmd.data;
		end
		if (adv_s2 && valid_s1) begin
			item_s2 <= core_res;
		end
	end

	hsc_core u_core (
		.data_bits (data_bits_q),
		.cmd_item  (item_s1),
		.res_item  (core_res)
	);

endmodule

### rtl/core/hsc_core.sv
// Combinational encode and check/correct logic for one item.
// Depends on hsc_pkg for the item types and widths.
`timescale 1ns / 1ps

module hsc_core (
	input  logic [hsc_pkg::DATA_BITS_W-1:0] data_bits,
	input  hsc_pkg::cmd_t                   cmd_item,
	output hsc_pkg::res_t                   res_item
);

	localparam int CW = hsc_pkg::MAX_CODE_BITS;
	localparam int DW = hsc_pkg::MAX_DATA_BITS;
	localparam int SW = hsc_pkg::SYND_W;

	function automatic logic [CW-1:0] pos_mask(input int i);
		logic [CW-1:0] msk;
		msk = '0;
		for (int k = 0; k < CW; k++) begin
			msk[k] = (((k + 1) >> i) & 1) != 0;
		end
		return msk;
	endfunction

	function automatic logic [CW-1:0] scatter(input logic [DW-1:0] d);
		logic [CW-1:0] w;
		int j;
		w = '0;
		j = 0;
		for (int pos = 1; pos <= CW; pos++) begin
			if ((pos & (pos - 1)) != 0) begin
				w[pos-1] = d[j];
				j++;
			end
		end
		return w;
	endfunction

	function automatic logic [SW-1:0] code_len(input logic [SW-1:0] m);
		logic [2:0] r;
		logic       found;
		r = '0;
		found = 1'b0;
		for (int k = 0; k < 7; k++) begin
			if (!found && ((8'd1 << k) >= ({2'b00, m} + 8'(k) + 8'd1))) begin
				r = 3'(k);
				found = 1'b1;
			end
		end
		return m + SW'(r);
	endfunction

	logic [SW-1:0] m_eff;
	logic [SW-1:0] n_len;
	logic [DW-1:0] d_mask;
	logic [CW-1:0] n_mask;
	logic [CW-1:0] enc_word;
	logic [CW-1:0] dec_word;
	logic [SW-1:0] synd;
	logic          oor;
	logic          corr;

	assign m_eff = (data_bits > SW'(DW)) ? SW'(DW) : data_bits;
	assign n_len = code_len(m_eff);

	always_comb begin
		for (int j = 0; j < DW; j++) begin
			d_mask[j] = SW'(j) < m_eff;
		end
		for (int k = 0; k < CW; k++) begin
			n_mask[k] = SW'(k) < n_len;
		end
	end

	always_comb begin
		enc_word = scatter(cmd_item.data_word & d_mask);
		for (int i = 0; i < SW; i++) begin
			enc_word[(1 << i) - 1] = ^(enc_word & pos_mask(i));
		end
	end

	always_comb begin
		dec_word = cmd_item.code_word & n_mask;
		for (int i = 0; i < SW; i++) begin
			synd[i] = ^(dec_word & pos_mask(i));
		end
		oor  = synd > n_len;
		corr = !oor && (synd != '0);
		if (corr) begin
			dec_word = dec_word ^ (CW'(1) << (synd - SW'(1)));
		end
	end

	always_comb begin
		case (cmd_item.op)
			hsc_pkg::OP_DECODE: begin
				res_item.code_out              = dec_word;
				res_item.syndrome              = synd;
				res_item.corrected             = corr;
				res_item.syndrome_out_of_range = oor;
			end
			default: begin
				res_item.code_out              = enc_word;
				res_item.syndrome              = '0;
				res_item.corrected             = 1'b0;
				res_item.syndrome_out_of_range = 1'b0;
			end
		endcase
	end

endmodule

### rtl/core/hsc_checker.sv
// Port-level assertions for the codec top level, attached by the bind at the end.
// Depends on hsc_pkg for the result item type.
`timescale 1ns / 1ps

module hsc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          res_valid,
	input logic          res_ready,
	input hsc_pkg::res_t res_data
);

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_data.corrected && res_data.syndrome_out_of_range))
		else $error("corrected and out-of-range flags both set");

	a_corrected_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.corrected |-> res_data.syndrome != '0)
		else $error("correction reported with a zero syndrome");

	a_oor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.syndrome_out_of_range |-> res_data.syndrome != '0)
		else $error("out-of-range flag with a zero syndrome");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("stalled result item changed");

endmodule

bind hamming_sec_codec_top hsc_checker u_hsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);
